@@ sv/dstk_pkg.sv @@
// Shared types for the duplicate-free stack: sequencer states, status codes
// and the result record passed from the sequencer to the top level.
// No dependencies.
`default_nettype none

package dstk_pkg;

    // Width of the fixed value and status fields on the ports.
    localparam int unsigned PORT_WIDTH   = 32;
    localparam int unsigned STATUS_WIDTH = 3;

    // Result status codes.
    typedef enum logic [STATUS_WIDTH-1:0] {
        STAT_OK          = 3'd0,
        STAT_DUP_DROPPED = 3'd1,
        STAT_DUP_MOVED   = 3'd2,
        STAT_POP_EMPTY   = 3'd3,
        STAT_FULL        = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_APPEND,
        S_POP_RD,
        S_POP_DONE
    } state_t;

    // One finished result.
    typedef struct packed {
        logic [PORT_WIDTH-1:0] popped;
        status_t               status;
        logic                  is_empty;
    } result_t;

endpackage

`default_nettype wire

@@ sv/dedup_stack.sv @@
// Top level of the duplicate-free stack: mode register, sequencer and the
// registered result ports.
// Depends on dstk_pkg and dstk_ctrl.
//
//  Channel   Handshake               Signals
//  -------   ---------------------   -----------------------------------
//  command   start & !busy           action, item_value
//  result    done (one cycle)        popped_value, status, is_empty
//  config    cfg_valid & cfg_ready   cfg_data (keep_newest)
//
// The sequencer reads and writes the entry RAM at most once per cycle and
// compares one entry per search step (S_SRCH_RD, S_SRCH_CMP) from slot 0 up.
// A pop reads the top entry; a pop on an empty stack needs no RAM access. A
// new value is appended after the search; a push onto a full stack ends there.
// A duplicate is dropped, or moved to the top as the entries above shift down.
// Reset clears the entry count and sets keep_newest; the RAM needs no clearing.
// The result receiver cannot stall; each result is shown for one cycle.
`default_nettype none

module dedup_stack #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         start,
    output logic                                              busy,
    input  wire logic                                         action,
    input  wire logic [dstk_pkg::PORT_WIDTH-1:0]              item_value,
    output logic                                              done,
    output logic      [dstk_pkg::PORT_WIDTH-1:0]              popped_value,
    output logic      [dstk_pkg::STATUS_WIDTH-1:0]            status,
    output logic                                              is_empty,
    input  wire logic                                         cfg_valid,
    output logic                                              cfg_ready,
    input  wire logic                                         cfg_data
);

    logic              keep_newest_reg;
    logic              done_reg;
    dstk_pkg::result_t res_reg;
    logic              fin_valid;
    dstk_pkg::result_t fin;

    assign cfg_ready = 1'b1;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_newest_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            keep_newest_reg <= cfg_data;
        end
    end

    dstk_ctrl #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .item_value  (item_value),
        .keep_newest (keep_newest_reg),
        .busy        (busy),
        .fin_valid   (fin_valid),
        .fin         (fin)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_valid;
        end
    end

    // Result payload, held until the next result.
    always_ff @(posedge clk)
    begin
        if (fin_valid)
        begin
            res_reg <= fin;
        end
    end

    assign done         = done_reg;
    assign popped_value = res_reg.popped;
    assign status       = res_reg.status;
    assign is_empty     = res_reg.is_empty;

endmodule

`default_nettype wire

@@ sv/dstk_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module dstk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/dstk_ctrl.sv @@
// Sequencer of the duplicate-free stack: searches, shifts, pushes and pops
// through one RAM port pair and one shared comparator.
// Depends on dstk_pkg and dstk_ram.
`default_nettype none

module dstk_ctrl #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic                               action,
    input  wire logic [dstk_pkg::PORT_WIDTH-1:0]    item_value,
    input  wire logic                               keep_newest,
    output logic                                    busy,
    output logic                                    fin_valid,
    output dstk_pkg::result_t                       fin
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    dstk_pkg::state_t state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  act_reg, act_next;
    logic [ITEM_WIDTH-1:0] val_reg, val_next;

    // RAM port signals.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    // Shared compare and increment.
    logic          match;
    logic [CW-1:0] idx_inc;
    logic [AW-1:0] top_addr;
    logic          at_last;
    logic          is_full;

    assign match    = (ram_rdata == val_reg);
    assign idx_inc  = CW'(idx_reg) + CW'(1);
    assign top_addr = AW'(count_reg - CW'(1));
    assign at_last  = (idx_inc >= count_reg);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign busy     = (state_reg != dstk_pkg::S_IDLE);

    dstk_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dstk_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current beat.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        act_reg <= act_next;
        val_reg <= val_next;
    end

    // Next state, index and count.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        act_next   = act_reg;
        val_next   = val_reg;
        unique case (state_reg)
            dstk_pkg::S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    val_next   = ITEM_WIDTH'(item_value);
                    idx_next   = '0;
                    state_next = dstk_pkg::S_CHECK;
                end
            end
            dstk_pkg::S_CHECK:
            begin
                if (act_reg)
                begin
                    state_next = (count_reg == '0) ? dstk_pkg::S_IDLE : dstk_pkg::S_POP_RD;
                end
                else
                begin
                    state_next = (count_reg == '0) ? dstk_pkg::S_APPEND : dstk_pkg::S_SRCH_RD;
                end
            end
            dstk_pkg::S_SRCH_RD:
            begin
                state_next = dstk_pkg::S_SRCH_CMP;
            end
            dstk_pkg::S_SRCH_CMP:
            begin
                if (match)
                begin
                    state_next = keep_newest ? dstk_pkg::S_SHIFT_RD : dstk_pkg::S_IDLE;
                end
                else if (at_last)
                begin
                    state_next = is_full ? dstk_pkg::S_IDLE : dstk_pkg::S_APPEND;
                end
                else
                begin
                    idx_next   = AW'(idx_inc);
                    state_next = dstk_pkg::S_SRCH_RD;
                end
            end
            dstk_pkg::S_SHIFT_RD:
            begin
                state_next = at_last ? dstk_pkg::S_PUT : dstk_pkg::S_SHIFT_WR;
            end
            dstk_pkg::S_SHIFT_WR:
            begin
                idx_next   = AW'(idx_inc);
                state_next = dstk_pkg::S_SHIFT_RD;
            end
            dstk_pkg::S_PUT:
            begin
                state_next = dstk_pkg::S_IDLE;
            end
            dstk_pkg::S_APPEND:
            begin
                count_next = count_reg + CW'(1);
                state_next = dstk_pkg::S_IDLE;
            end
            dstk_pkg::S_POP_RD:
            begin
                count_next = count_reg - CW'(1);
                state_next = dstk_pkg::S_POP_DONE;
            end
            dstk_pkg::S_POP_DONE:
            begin
                state_next = dstk_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dstk_pkg::S_IDLE;
            end
        endcase
    end

    // RAM accesses and finished results.
    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg;
        fin_valid    = 1'b0;
        fin.popped   = '0;
        fin.status   = dstk_pkg::STAT_OK;
        fin.is_empty = (count_next == '0);
        unique case (state_reg)
            dstk_pkg::S_CHECK:
            begin
                if (act_reg && (count_reg == '0))
                begin
                    fin_valid  = 1'b1;
                    fin.status = dstk_pkg::STAT_POP_EMPTY;
                end
            end
            dstk_pkg::S_SRCH_RD:
            begin
                ram_re = 1'b1;
            end
            dstk_pkg::S_SRCH_CMP:
            begin
                if (match)
                begin
                    if (!keep_newest)
                    begin
                        fin_valid  = 1'b1;
                        fin.status = dstk_pkg::STAT_DUP_DROPPED;
                    end
                end
                else if (at_last && is_full)
                begin
                    fin_valid  = 1'b1;
                    fin.status = dstk_pkg::STAT_FULL;
                end
            end
            dstk_pkg::S_SHIFT_RD:
            begin
                // Fetch the entry just above the gap.
                if (!at_last)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(idx_inc);
                end
            end
            dstk_pkg::S_SHIFT_WR:
            begin
                ram_we = 1'b1;
            end
            dstk_pkg::S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = top_addr;
                ram_wdata  = val_reg;
                fin_valid  = 1'b1;
                fin.status = dstk_pkg::STAT_DUP_MOVED;
            end
            dstk_pkg::S_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_reg);
                ram_wdata = val_reg;
                fin_valid = 1'b1;
            end
            dstk_pkg::S_POP_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = top_addr;
            end
            dstk_pkg::S_POP_DONE:
            begin
                fin_valid  = 1'b1;
                fin.popped = dstk_pkg::PORT_WIDTH'(ram_rdata);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ bench/tb_dedup_stack.sv @@
// Self-checking testbench for dedup_stack: a directed table followed by random phases,
// with each response checked against the table's result or a shadow stack kept here.
// Depends on dstk_pkg and the dedup_stack RTL.
`timescale 1ns / 1ps

module tb_dedup_stack;

    localparam int unsigned STACK_DEPTH  = 16;
    localparam int unsigned VALUE_WIDTH  = 32;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned POOL_SIZE    = 20;
    localparam int unsigned SETTLE_WAIT  = 100;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // Command codes and mode values.
    localparam logic ACT_PUSH         = 1'b0;
    localparam logic ACT_POP          = 1'b1;
    localparam logic MODE_KEEP_OLDEST = 1'b0;
    localparam logic MODE_KEEP_NEWEST = 1'b1;

    localparam logic [VALUE_WIDTH-1:0] ALL_ZEROS = '0;
    localparam logic [VALUE_WIDTH-1:0] ALL_ONES  = '1;

    typedef enum logic { ROW_CMD, ROW_MODE } row_kind_t;

    // One line of the directed table; want is used only when typed is set.
    typedef struct {
        row_kind_t               kind;
        logic                    act;
        logic [VALUE_WIDTH-1:0]  val;
        bit                      typed;
        dstk_pkg::result_t       want;
    } stim_row_t;

    logic                                  clk;
    logic                                  rst_n      = 1'b0;
    logic                                  start      = 1'b0;
    logic                                  action     = ACT_PUSH;
    logic [dstk_pkg::PORT_WIDTH-1:0]       item_value = '0;
    logic                                  cfg_valid  = 1'b0;
    logic                                  cfg_data   = 1'b0;
    logic                                  busy;
    logic                                  done;
    logic [dstk_pkg::PORT_WIDTH-1:0]       popped_value;
    logic [dstk_pkg::STATUS_WIDTH-1:0]     status;
    logic                                  is_empty;
    logic                                  cfg_ready;

    // Shadow copy of the stack and its mode.
    logic [VALUE_WIDTH-1:0]      shadow_entries [STACK_DEPTH];
    int                          shadow_count;
    logic                        shadow_keep_newest;

    dstk_pkg::result_t           owed_responses [$];
    stim_row_t                   stim_table [$];
    logic [VALUE_WIDTH-1:0]      value_pool [POOL_SIZE];
    int                          mismatch_count;

    dedup_stack #(
        .DEPTH      (STACK_DEPTH),
        .ITEM_WIDTH (VALUE_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .item_value   (item_value),
        .done         (done),
        .popped_value (popped_value),
        .status       (status),
        .is_empty     (is_empty),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string msg);
    begin
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    end
    endtask

    // Applies one push or pop to the shadow stack and returns the response it owes.
    function automatic dstk_pkg::result_t apply_stack_op(input logic act,
                                                         input logic [VALUE_WIDTH-1:0] val);
        dstk_pkg::result_t res;
        int      slot;
        int      i;
        res        = '0;
        res.status = dstk_pkg::STAT_OK;
        if (act == ACT_POP)
        begin
            if (shadow_count == 0)
                res.status = dstk_pkg::STAT_POP_EMPTY;
            else
            begin
                shadow_count--;
                res.popped = shadow_entries[shadow_count];
            end
        end
        else
        begin
            // Lowest slot holding the value, or -1 when absent.
            slot = -1;
            for (i = shadow_count - 1; i >= 0; i--)
                if (shadow_entries[i] == val)
                    slot = i;
            if (slot >= 0)
            begin
                if (shadow_keep_newest)
                begin
                    // Close the gap and put the value back on top.
                    for (i = slot; i < shadow_count - 1; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_entries[shadow_count - 1] = val;
                    res.status = dstk_pkg::STAT_DUP_MOVED;
                end
                else
                    res.status = dstk_pkg::STAT_DUP_DROPPED;
            end
            else if (shadow_count >= STACK_DEPTH)
                res.status = dstk_pkg::STAT_FULL;
            else
            begin
                shadow_entries[shadow_count] = val;
                shadow_count++;
            end
        end
        res.is_empty = (shadow_count == 0);
        return res;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic act,
                                    input logic [VALUE_WIDTH-1:0] val, input bit typed,
                                    input logic [dstk_pkg::PORT_WIDTH-1:0] w_popped,
                                    input dstk_pkg::status_t w_status, input logic w_empty);
        stim_row_t r;
        r.kind          = kind;
        r.act           = act;
        r.val           = val;
        r.typed         = typed;
        r.want.popped   = w_popped;
        r.want.status   = w_status;
        r.want.is_empty = w_empty;
        stim_table.push_back(r);
    endfunction

    // Presents one command and holds it until the beat is taken.
    task automatic send_cmd(input logic act, input logic [VALUE_WIDTH-1:0] val,
                            input bit typed, input dstk_pkg::result_t want);
        dstk_pkg::result_t predicted;
    begin
        start      <= 1'b1;
        action     <= act;
        item_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_stack_op(act, val);
        owed_responses.push_back(typed ? want : predicted);
    end
    endtask

    // Drops start for a number of cycles with noise on the command fields.
    task automatic idle_gap(input int unsigned cycles);
    begin
        if (cycles > 0)
        begin
            start      <= 1'b0;
            action     <= 1'($urandom);
            item_value <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    end
    endtask

    // Holds the sender off until every owed response has come back.
    task automatic wait_drained();
    begin
        start <= 1'b0;
        while (owed_responses.size() != 0)
            @(posedge clk);
    end
    endtask

    // Writes the mode register while the block is idle.
    task automatic set_mode(input logic mode);
    begin
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_keep_newest = mode;
    end
    endtask

    // Mostly values from a small pool so duplicates are common.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 66)
            return ($urandom_range(0, 1) != 0) ? ALL_ONES : ALL_ZEROS;
        else
            return $urandom;
    endfunction

    // Response checker: every done beat is matched against the oldest owed response.
    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (owed_responses.size() == 0)
                flag_mismatch("response with nothing outstanding");
            else
            begin
                if (popped_value !== owed_responses[0].popped)
                    flag_mismatch($sformatf("popped_value got %08h want %08h",
                                            popped_value, owed_responses[0].popped));
                if (status !== owed_responses[0].status)
                    flag_mismatch($sformatf("status got %0d want %0d",
                                            status, owed_responses[0].status));
                if (is_empty !== owed_responses[0].is_empty)
                    flag_mismatch($sformatf("is_empty got %0b want %0b",
                                            is_empty, owed_responses[0].is_empty));
                void'(owed_responses.pop_front());
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, final verdict.
    initial
    begin
        int unsigned push_pct [PHASE_COUNT] = '{85, 50, 25, 90, 60, 40, 75, 55};
        int unsigned burst_left;
        logic        act;
        int          p;
        int          n;

        mismatch_count     = 0;
        shadow_count       = 0;
        shadow_keep_newest = MODE_KEEP_NEWEST;

        // Directed table: empty pop, extremes, both duplicate modes, full stack.
        add_row(ROW_CMD,  ACT_POP,  ALL_ZEROS, 1, '0, dstk_pkg::STAT_POP_EMPTY, 1'b1);
        add_row(ROW_CMD,  ACT_PUSH, ALL_ZEROS, 1, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, ALL_ONES,  1, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, ALL_ONES,  1, '0, dstk_pkg::STAT_DUP_MOVED, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, ALL_ZEROS, 1, '0, dstk_pkg::STAT_DUP_MOVED, 1'b0);
        add_row(ROW_CMD,  ACT_POP,  ALL_ONES,  1, ALL_ZEROS, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_MODE, ACT_PUSH, {31'd0, MODE_KEEP_OLDEST}, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, ALL_ONES,  1, '0, dstk_pkg::STAT_DUP_DROPPED, 1'b0);
        add_row(ROW_MODE, ACT_PUSH, {31'd0, MODE_KEEP_NEWEST}, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        // Fill up to the full depth; these are checked by the shadow stack.
        add_row(ROW_CMD,  ACT_PUSH, 32'h0000_0001, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h8000_0000, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h5555_5555, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'hAAAA_AAAA, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h7FFF_FFFF, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'hFFFF_FFFE, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h0000_FFFF, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'hFFFF_0000, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h1234_5678, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h8765_4321, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h0F0F_0F0F, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'hF0F0_F0F0, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h0000_0002, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h4000_0000, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, 32'h3C3C_C3C3, 0, '0, dstk_pkg::STAT_OK, 1'b0);
        // New value on a full stack, then the bottom entry moved to the top.
        add_row(ROW_CMD,  ACT_PUSH, ALL_ZEROS, 1, '0, dstk_pkg::STAT_FULL, 1'b0);
        add_row(ROW_CMD,  ACT_PUSH, ALL_ONES,  1, '0, dstk_pkg::STAT_DUP_MOVED, 1'b0);
        add_row(ROW_CMD,  ACT_POP,  ALL_ZEROS, 1, ALL_ONES, dstk_pkg::STAT_OK, 1'b0);

        // Reset, released on a clock edge.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table back to back.
        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_MODE)
                set_mode(stim_table[i].val[0]);
            else
                send_cmd(stim_table[i].act, stim_table[i].val,
                         stim_table[i].typed, stim_table[i].want);
        end

        // Random phases; each one starts idle with a fresh mode and value pool.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            set_mode((p % 2 == 0) ? MODE_KEEP_OLDEST : MODE_KEEP_NEWEST);
            foreach (value_pool[i])
                value_pool[i] = $urandom;
            burst_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Bursts of commands with gaps; long gaps let the block go idle.
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 9) == 0)
                        idle_gap($urandom_range(10, 60));
                    else
                        idle_gap($urandom_range(0, 4));
                end
                act = ($urandom_range(0, 99) < push_pct[p]) ? ACT_PUSH : ACT_POP;
                send_cmd(act, pick_value(), 0, '0);
                burst_left--;
            end
        end

        // Let everything owed come back, then a little longer for stray beats.
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ dedup_stack.f @@
sv/dstk_pkg.sv
sv/dstk_ram.sv
sv/dstk_ctrl.sv
sv/dedup_stack.sv
bench/tb_dedup_stack.sv
